// ===== rtl/assert_macros.svh =====
// shared assertion macros for the list engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define OLE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define OLE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ole_pkg.sv =====
package ole_pkg;

  localparam int DATA_W           = 32;
  localparam int DEFAULT_CAPACITY = 16;

  // command codes
  localparam logic [2:0] OP_FRONT  = 3'd0;
  localparam logic [2:0] OP_END    = 3'd1;
  localparam logic [2:0] OP_POS    = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_LIST_F = 3'd4;
  localparam logic [2:0] OP_LIST_R = 3'd5;

  // result status codes
  localparam logic [2:0] STAT_INSERTED  = 3'd0;
  localparam logic [2:0] STAT_FULL      = 3'd1;
  localparam logic [2:0] STAT_DELETED   = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [2:0] STAT_EMPTY     = 3'd4;
  localparam logic [2:0] STAT_LISTED    = 3'd5;

  // cell modes
  localparam logic [2:0] CM_HOLD   = 3'd0;
  localparam logic [2:0] CM_INSERT = 3'd1;
  localparam logic [2:0] CM_ROT_L  = 3'd2;
  localparam logic [2:0] CM_ROT_R  = 3'd3;
  localparam logic [2:0] CM_CLOSE  = 3'd4;

  typedef struct packed {
    logic        [2:0]        operation;
    logic signed [DATA_W-1:0] token;
    logic signed [15:0]       position;
  } cmd_t;

  typedef struct packed {
    logic        [2:0]        status;
    logic signed [DATA_W-1:0] entry_value;
    logic        [4:0]        entry_count;
    logic                     last;
  } result_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [DATA_W-1:0] token;
  } ole_ctl_t;

endpackage

// ===== rtl/ordered_list_engine.sv =====
// Ordered list of up to CAPACITY signed tokens held in a ring of cells, front at cell 0.
// An insert opens a gap in the cells in one step, registering its result in the same cycle.
// Delete and both listings on a non-empty list rotate the whole ring once, CAPACITY steps,
// so the list is back in place at the end; delete adds one closing step. On an empty list
// they give STAT_EMPTY without rotating. A listing emits one result per rotation step
// over the stored entries and holds the ring while the result side stalls. A new request
// is taken once the previous one is done, closing step included, even while its last
// result waits. Operation codes 6 and 7 are taken and dropped with no result.
`include "assert_macros.svh"

module ordered_list_engine import ole_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  output result_t result,
  output logic    result_valid,
  input  logic    result_ready
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = $clog2(CAPACITY);
  localparam int XW = (CW > 16) ? CW : 16;
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [KW-1:0] K_LAST = KW'(CAPACITY - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_CLOSE = 2'd2;

  logic [1:0]        state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [KW-1:0]     k, k_next;
  logic [2:0]        op, op_next;
  logic [DATA_W-1:0] token, token_next;
  logic [CW-1:0]     ins_idx, ins_idx_next, ins_idx_new;
  logic              found, found_next;
  logic [CW-1:0]     match_idx, match_idx_next;
  logic              out_valid, out_free, emit;
  result_t           out_data, res;

  logic [15:0]       pm1, pclamp;
  logic [CW-1:0]     k_ext;
  logic              rev_need;

  ole_ctl_t          ctl;
  logic [CW-1:0]     cell_pos;
  logic [DATA_W-1:0] cell_value [CAPACITY];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      ole_cell #(
        .INDEX (gi),
        .CW    (CW)
      ) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .pos         (cell_pos),
        .lim         (count),
        .left_value  (cell_value[(gi + CAPACITY - 1) % CAPACITY]),
        .right_value (cell_value[(gi + 1) % CAPACITY]),
        .value       (cell_value[gi])
      );
    end
  endgenerate

  assign cmd_ready    = (state == S_IDLE);
  assign out_free     = !out_valid || result_ready;
  assign result_valid = out_valid;
  assign result       = out_data;

  // insert index for a new request
  assign pm1 = 16'(cmd.position - 16'sd1);
  always_comb begin
    pclamp      = (pm1 < 16'd1) ? 16'd1 : pm1;
    ins_idx_new = '0;
    case (cmd.operation)
      OP_END: ins_idx_new = count;
      OP_POS: begin
        if (cmd.position <= 16'sd0) begin
          ins_idx_new = '0;
        end else if (XW'(pclamp) > XW'(count)) begin
          ins_idx_new = count;
        end else begin
          ins_idx_new = CW'(pclamp);
        end
      end
      default: ins_idx_new = '0;
    endcase
  end

  assign k_ext    = CW'(k);
  assign rev_need = ((CW + 1)'(k) + (CW + 1)'(count)) >= (CW + 1)'(CAPACITY);

  always_comb begin
    state_next     = state;
    count_next     = count;
    k_next         = k;
    op_next        = op;
    token_next     = token;
    ins_idx_next   = ins_idx;
    found_next     = found;
    match_idx_next = match_idx;
    ctl.mode       = CM_HOLD;
    ctl.token      = token;
    cell_pos       = ins_idx;
    emit           = 1'b0;
    res.status      = STAT_INSERTED;
    res.entry_value = '0;
    res.last        = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid && cmd.operation <= OP_LIST_R) begin
          state_next   = S_RUN;
          op_next      = cmd.operation;
          token_next   = cmd.token;
          ins_idx_next = ins_idx_new;
          k_next       = '0;
          found_next   = 1'b0;
        end
      end
      S_RUN: begin
        case (op) inside
          OP_FRONT, OP_END, OP_POS: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = S_IDLE;
              if (count == CAP_C) begin
                res.status = STAT_FULL;
              end else begin
                ctl.mode   = CM_INSERT;
                count_next = count + CW'(1);
              end
            end
          end
          OP_DELETE, OP_LIST_F, OP_LIST_R: begin
            if (count == '0) begin
              if (out_free) begin
                emit       = 1'b1;
                res.status = STAT_EMPTY;
                state_next = S_IDLE;
              end
            end else if (op == OP_DELETE) begin
              // scan the front cell while the ring turns once
              ctl.mode = CM_ROT_L;
              if (k_ext < count && !found && cell_value[0] == token) begin
                found_next     = 1'b1;
                match_idx_next = k_ext;
              end
              k_next = k + KW'(1);
              if (k == K_LAST) begin
                state_next = S_CLOSE;
              end
            end else if (op == OP_LIST_F) begin
              if (k_ext >= count || out_free) begin
                ctl.mode = CM_ROT_L;
                if (k_ext < count) begin
                  emit            = 1'b1;
                  res.status      = STAT_LISTED;
                  res.entry_value = cell_value[0];
                  res.last        = (k_ext + CW'(1)) == count;
                end
                k_next = k + KW'(1);
                if (k == K_LAST) begin
                  state_next = S_IDLE;
                end
              end
            end else begin
              // the tail reaches the last cell once the ring has turned CAPACITY - count
              if (!rev_need || out_free) begin
                ctl.mode = CM_ROT_R;
                if (rev_need) begin
                  emit            = 1'b1;
                  res.status      = STAT_LISTED;
                  res.entry_value = cell_value[CAPACITY-1];
                  res.last        = (k == K_LAST);
                end
                k_next = k + KW'(1);
                if (k == K_LAST) begin
                  state_next = S_IDLE;
                end
              end
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_CLOSE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (found) begin
            ctl.mode   = CM_CLOSE;
            cell_pos   = match_idx;
            count_next = count - CW'(1);
            res.status = STAT_DELETED;
          end else begin
            res.status = STAT_NOT_FOUND;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    res.entry_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      k         <= '0;
      found     <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      k     <= k_next;
      found <= found_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    token     <= token_next;
    ins_idx   <= ins_idx_next;
    match_idx <= match_idx_next;
    if (emit) begin
      out_data <= res;
    end
  end

  `OLE_ASSERT(a_count_cap, (count <= CAP_C), "entry count above capacity")
  `OLE_ASSERT(a_listed_nonempty, (out_valid && out_data.status == STAT_LISTED) |-> (count != '0), "listed entry from empty list")
  `OLE_ASSERT(a_zero_value, (out_valid && out_data.status != STAT_LISTED) |-> (out_data.entry_value == '0), "nonzero value on status result")
  `OLE_ASSERT(a_insert_grows, (state == S_RUN && (op == OP_FRONT || op == OP_END || op == OP_POS) && count != CAP_C && out_free) |=> (count == $past(count) + CW'(1)), "insert did not grow list")
  `OLE_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !out_valid), "not idle after reset")

endmodule

// ===== rtl/ole_cell.sv =====
module ole_cell import ole_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  logic              clk,
  input  ole_ctl_t          ctl,
  input  logic [CW-1:0]     pos,
  input  logic [CW-1:0]     lim,
  input  logic [DATA_W-1:0] left_value,
  input  logic [DATA_W-1:0] right_value,
  output logic [DATA_W-1:0] value
);

  localparam logic [CW-1:0] IDX  = CW'(INDEX);
  localparam logic [CW-1:0] IDX1 = CW'(INDEX + 1);

  logic [DATA_W-1:0] value_next;

  always_comb begin
    value_next = value;
    unique case (ctl.mode)
      CM_INSERT: begin
        // open a gap at pos, entries up to lim move one place back
        if (IDX == pos) begin
          value_next = ctl.token;
        end else if (IDX > pos && IDX <= lim) begin
          value_next = left_value;
        end
      end
      CM_ROT_L: value_next = right_value;
      CM_ROT_R: value_next = left_value;
      CM_CLOSE: begin
        if (IDX >= pos && IDX1 < lim) begin
          value_next = right_value;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
